[rtl/core/sorted_key_value_table_top_assert.svh]
// ----------------------------------------------------------------------------
// sorted key/value table assertion macros
// concurrent checks on the top level, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_TABLE_TOP_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked every cycle out of reset
`define SKVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define SKVT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SKVT_ASSERT(lbl, prop, msg)
`define SKVT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[rtl/core/skvt_pkg.sv]
// ----------------------------------------------------------------------------
// skvt_pkg
// shared constants, codes and cell link types of the sorted key/value table
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int DEPTH      = 64;
  localparam int KEY_BYTES  = 8;
  localparam int KEY_BITS   = KEY_BYTES * 8;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // fixed field widths of the channels
  localparam int FUNC_W     = 2;
  localparam int KEY_W      = 64;
  localparam int VAL_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int ECOUNT_W   = 7;
  localparam int CAP_W      = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT    = 2'd0,
    FUNC_GET    = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic                  gt;
  } link_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic                  ins;
    logic                  upd;
    logic                  rem;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } cmd_t;

endpackage

[rtl/core/skvt_req_if.sv]
// ----------------------------------------------------------------------------
// skvt_req_if
// request channel: operation, key and value with valid/ready
// ----------------------------------------------------------------------------
interface skvt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] key;
  logic [31:0] value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);
endinterface

[rtl/core/skvt_rsp_if.sv]
// ----------------------------------------------------------------------------
// skvt_rsp_if
// response channel: status, hit flag, value and entry count with valid/ready
// ----------------------------------------------------------------------------
interface skvt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [31:0] value_out;
  logic [6:0]  entry_count;

  modport source (output valid, output status, output found, output value_out,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found, input value_out,
                  input entry_count, output ready);
endinterface

[rtl/core/skvt_cell.sv]
// ----------------------------------------------------------------------------
// skvt_cell
// one table slot: holds a key/value pair, compares it against the request
// key and shifts to or from its neighbors on insert and remove
// ----------------------------------------------------------------------------
module skvt_cell (
  input  logic                           clk,
  input  logic                           cmp_en,
  input  logic [skvt_pkg::KEY_BITS-1:0]  cmp_key,
  input  logic                           live,
  input  logic                           at_count,
  input  logic                           commit,
  input  skvt_pkg::cmd_t                 cmd,
  input  skvt_pkg::link_t                left,
  input  skvt_pkg::link_t                right,
  output skvt_pkg::link_t                self_link,
  output logic                           hit,
  output logic [skvt_pkg::VALUE_BITS-1:0] value_q
);
  import skvt_pkg::*;

  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;
  logic                  eq;
  logic                  gt;

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      eq <= live && (key == cmp_key);
      gt <= live && (key > cmp_key);
    end
    if (commit) begin
      if (cmd.ins) begin
        // everything above the new key moves up by one
        if (left.gt) begin
          key   <= left.key;
          value <= left.value;
        end else if (gt || at_count) begin
          key   <= cmd.key;
          value <= cmd.value;
        end
      end else if (cmd.upd) begin
        if (eq) begin
          value <= cmd.value;
        end
      end else if (cmd.rem) begin
        // the hit slot and everything above it close the gap
        if (eq || gt) begin
          key   <= right.key;
          value <= right.value;
        end
      end
    end
  end

  assign self_link.key   = key;
  assign self_link.value = value;
  assign self_link.gt    = gt;
  assign hit             = eq;
  assign value_q         = value;

endmodule

[rtl/core/sorted_key_value_table_top.sv]
// ----------------------------------------------------------------------------
// sorted_key_value_table_top
// sorted key/value table built as a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// usage:
//   req carries one operation per beat (func 0 put, 1 get, 2 remove) with a
//   64-bit key and a 32-bit value; rsp returns one beat per request with
//   status, found, value_out and the entry count after the operation.
//   cfg_we/cfg_wdata write the capacity register (reset 64); the user must
//   write it only while idle; the block itself leaves this unenforced.
// timing:
//   a request beat is compared against every cell at the accepting edge;
//   the commit then shifts the chain and loads the response register, but
//   waits while rsp holds an untaken response. a new request is taken only
//   after that commit; one compare/shift pass covers all cells in parallel.
// reset:
//   rst (synchronous, active high) empties the table and sets capacity 64;
//   slot contents are not cleared, only the entry count.
// stalls:
//   one request may be taken while a response waits on rsp; that request
//   then holds in the compare stage until the response register frees up.
// ----------------------------------------------------------------------------
module sorted_key_value_table_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [skvt_pkg::CAP_W-1:0] cfg_wdata,
  skvt_req_if.sink                  req,
  skvt_rsp_if.source                rsp
);
  import skvt_pkg::*;

  logic [CAP_W-1:0]      capacity;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  busy;
  logic [FUNC_W-1:0]     func;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  logic                  accept;
  logic                  commit;
  logic                  full;
  logic                  any_hit;
  logic [VALUE_BITS-1:0] hit_value;
  cmd_t                  cmd;

  logic [DEPTH-1:0]      live;
  logic [DEPTH-1:0]      at_count;
  logic [DEPTH-1:0]      hit;
  link_t                 links  [DEPTH];
  logic [VALUE_BITS-1:0] values [DEPTH];

  logic [STATUS_W-1:0]   status_next;
  logic                  found_next;
  logic [VAL_W-1:0]      value_out_next;

  assign accept    = req.valid && req.ready;
  assign req.ready = !busy;
  assign commit    = busy && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (commit) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func  <= req.func;
      key   <= req.key[KEY_BITS-1:0];
      value <= req.value[VALUE_BITS-1:0];
    end
  end

  // per-slot occupancy from the entry count
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      live[i]     = (32'(i) < 32'(count));
      at_count[i] = (32'(i) == 32'(count));
    end
  end

  // keys are unique, so at most one slot hits
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_value = hit_value | (values[i] & {VALUE_BITS{hit[i]}});
    end
  end

  assign any_hit = |hit;
  assign full    = (32'(count) >= 32'(capacity)) || (32'(count) >= 32'(DEPTH));

  always_comb begin
    cmd.ins        = 1'b0;
    cmd.upd        = 1'b0;
    cmd.rem        = 1'b0;
    cmd.key        = key;
    cmd.value      = value;
    status_next    = STAT_OK;
    found_next     = 1'b0;
    value_out_next = '0;
    count_next     = count;
    unique case (func) inside
      FUNC_PUT: begin
        if (full) begin
          status_next = STAT_FULL;
        end else if (any_hit) begin
          cmd.upd = 1'b1;
        end else begin
          cmd.ins    = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      FUNC_GET, FUNC_REMOVE: begin
        if (!any_hit) begin
          status_next = STAT_NOT_FOUND;
        end else begin
          found_next     = 1'b1;
          value_out_next = VAL_W'(hit_value);
          if (func == FUNC_REMOVE) begin
            cmd.rem    = 1'b1;
            count_next = count - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.status      <= status_next;
      rsp.found       <= found_next;
      rsp.value_out   <= value_out_next;
      rsp.entry_count <= ECOUNT_W'(count_next);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    link_t left_link;
    link_t right_link;

    if (g == 0) begin : g_first
      assign left_link = '0;
    end else begin : g_mid_l
      assign left_link = links[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_link = '0;
    end else begin : g_mid_r
      assign right_link = links[g+1];
    end

    skvt_cell u_cell (
      .clk       (clk),
      .cmp_en    (accept),
      .cmp_key   (req.key[KEY_BITS-1:0]),
      .live      (live[g]),
      .at_count  (at_count[g]),
      .commit    (commit),
      .cmd       (cmd),
      .left      (left_link),
      .right     (right_link),
      .self_link (links[g]),
      .hit       (hit[g]),
      .value_q   (values[g])
    );
  end

  `include "sorted_key_value_table_top_assert.svh"

  `SKVT_ASSERT(a_count_bound, 32'(count) <= 32'(DEPTH), "entry count above table depth")
  `SKVT_ASSERT(a_single_hit, busy |-> $onehot0(hit), "more than one slot matched the key")
  `SKVT_ASSERT(a_count_only_on_commit, !commit |=> $stable(count), "count moved without commit")
  `SKVT_ASSERT(a_rsp_after_commit, commit |=> rsp.valid, "committed op left no response")
  `SKVT_ASSERT_ALWAYS(a_reset_idle, rst |=> (!busy && !rsp.valid), "reset left the table busy")

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted key/value table: a behavioral copy of
// the table predicts each response; put, get, remove and the unused code are
// driven with directed and random keys under several capacity settings,
// with random idle and stall phases and one long response hold-off
// ----------------------------------------------------------------------------
module tb_top;
  import skvt_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;  // no operation, answers ok
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 40;

  typedef struct packed {
    status_t             status;
    logic                found;
    logic [VAL_W-1:0]    value_out;
    logic [ECOUNT_W-1:0] entry_count;
  } table_answer_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  skvt_req_if req ();
  skvt_rsp_if rsp ();

  sorted_key_value_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  // behavioral copy of the table
  logic [KEY_W-1:0] model_keys [DEPTH];
  logic [VAL_W-1:0] model_vals [DEPTH];
  int               model_count = 0;
  logic [CAP_W-1:0] model_cap = CAP_RESET;

  table_answer_t    answer_q [$];
  logic [KEY_W-1:0] key_pool [$];
  int               error_count = 0;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      hold_len = 0;
  bit               hold_on = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int find_entry(logic [KEY_W-1:0] k);
    for (int i = 0; i < model_count; i++)
      if (model_keys[i] == k) return i;
    return -1;
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < model_count; i++) begin
      model_keys[i] = model_keys[i+1];
      model_vals[i] = model_vals[i+1];
    end
    model_count--;
  endfunction

  function automatic table_answer_t table_apply(logic [FUNC_W-1:0] op,
                                                logic [KEY_W-1:0] k,
                                                logic [VAL_W-1:0] v);
    table_answer_t r;
    int limit;
    int pos;
    int i;
    r = '0;
    r.status = STAT_OK;
    limit = (model_cap < DEPTH) ? int'(model_cap) : DEPTH;
    pos = find_entry(k);
    case (op) inside
      FUNC_PUT: begin
        // a full table refuses even a key it already holds
        if (model_count >= limit) begin
          r.status = STAT_FULL;
        end else begin
          if (pos >= 0) drop_entry(pos);
          i = model_count;
          while (i > 0 && model_keys[i-1] > k) begin
            model_keys[i] = model_keys[i-1];
            model_vals[i] = model_vals[i-1];
            i--;
          end
          model_keys[i] = k;
          model_vals[i] = v;
          model_count++;
        end
      end
      FUNC_GET, FUNC_REMOVE: begin
        if (pos < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          r.value_out = model_vals[pos];
          if (op == FUNC_REMOVE) drop_entry(pos);
        end
      end
      default: ;
    endcase
    r.entry_count = model_count[ECOUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    if (error_count < MAX_REPORTS)
      $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
    error_count++;
  endtask

  // predict on every request beat, check on every response beat
  always @(posedge clk) begin
    table_answer_t want;
    if (rst) begin
      model_count = 0;
      model_cap = CAP_RESET;
    end else begin
      if (cfg_we) model_cap = cfg_wdata;
      if (req.valid && req.ready)
        answer_q.push_back(table_apply(req.func, req.key, req.value));
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("response with nothing outstanding", '0, '0);
        end else begin
          want = answer_q.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(want.status), 64'(rsp.status));
          if (rsp.found !== want.found)
            report_mismatch("found", 64'(want.found), 64'(rsp.found));
          if (rsp.value_out !== want.value_out)
            report_mismatch("value_out", 64'(want.value_out), 64'(rsp.value_out));
          if (rsp.entry_count !== want.entry_count)
            report_mismatch("entry_count", 64'(want.entry_count), 64'(rsp.entry_count));
        end
      end
    end
  end

  // long response hold-off, counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        hold_on = 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_on = 1'b0;
        hold_len = 0;
      end
    end
  end

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no beat for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // valid stays high from one beat to the next unless a gap is taken
  task automatic send_op(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] k,
                         logic [VAL_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req.valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    @(negedge clk);
    req.valid <= 1'b1;
    req.func  <= op;
    req.key   <= k;
    req.value <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic send_random_op();
    logic [FUNC_W-1:0] op;
    logic [KEY_W-1:0]  k;
    int unsigned       r;
    r = $urandom_range(99);
    if (r < 45) op = FUNC_PUT;
    else if (r < 70) op = FUNC_GET;
    else if (r < 95) op = FUNC_REMOVE;
    else op = FUNC_UNUSED;
    // mostly pool keys so that lookups hit, now and then a fresh one
    if (key_pool.size() == 0 || $urandom_range(9) == 0) k = {$urandom(), $urandom()};
    else k = key_pool[$urandom_range(key_pool.size() - 1)];
    send_op(op, k, $urandom());
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req.valid <= 1'b0;
    while (answer_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_basic_ops();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_op(FUNC_GET,    64'h1234, '0);
    send_op(FUNC_REMOVE, 64'h1234, '0);
    send_op(FUNC_PUT,    64'h0, 32'hffff_ffff);
    send_op(FUNC_PUT,    64'hffff_ffff_ffff_ffff, 32'h0);
    send_op(FUNC_PUT,    64'h8000_0000_0000_0000, 32'ha5a5_a5a5);
    send_op(FUNC_PUT,    64'h7fff_ffff_ffff_ffff, 32'h5a5a_5a5a);
    // replacing a value answers like a plain put
    send_op(FUNC_PUT,    64'h8000_0000_0000_0000, 32'h1234_5678);
    send_op(FUNC_GET,    64'h0, '0);
    send_op(FUNC_GET,    64'hffff_ffff_ffff_ffff, '0);
    send_op(FUNC_GET,    64'h8000_0000_0000_0000, '0);
    send_op(FUNC_UNUSED, 64'h0, 32'h1);
    send_op(FUNC_REMOVE, 64'h7fff_ffff_ffff_ffff, '0);
    send_op(FUNC_REMOVE, 64'h7fff_ffff_ffff_ffff, '0);
    send_op(FUNC_GET,    64'h7fff_ffff_ffff_ffff, '0);
  endtask

  task automatic test_capacity_limits();
    write_capacity(CAP_W'(0));
    send_op(FUNC_PUT, 64'h5, 32'h55);
    write_capacity(CAP_W'(3));
    send_op(FUNC_PUT, 64'h5, 32'h55);
    send_op(FUNC_PUT, 64'h0, 32'h66);
    // limit below the entries held: lookups still work, puts fail
    write_capacity(CAP_W'(1));
    send_op(FUNC_GET,    64'h0, '0);
    send_op(FUNC_REMOVE, 64'h0, '0);
    send_op(FUNC_PUT,    64'h0, 32'h77);
    write_capacity(CAP_W'(127));
    send_op(FUNC_PUT, 64'h5, 32'h88);
    send_op(FUNC_PUT, 64'h6, 32'h99);
  endtask

  task automatic test_random_traffic(int n, int unsigned send_pct, int unsigned recv_pct,
                                     int cap, int pool_n);
    logic [KEY_W-1:0] base;
    write_capacity(CAP_W'(cap));
    key_pool.delete();
    base = {$urandom(), $urandom()};
    // some neighboring keys to exercise the low compare bits
    for (int i = 0; i < pool_n; i++)
      key_pool.push_back((i % 4 == 0) ? base + KEY_W'(i) : {$urandom(), $urandom()});
    key_pool.push_back('0);
    key_pool.push_back('1);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n; i++) begin
      send_random_op();
      if ($urandom_range(199) == 0) wait_idle();
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    hold_len = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_random_op();
    // let every response come home before going on
    wait_idle();
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.func  = '0;
    req.key   = '0;
    req.value = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_capacity_limits();
    test_random_traffic(450, 0, 0, 64, 100);
    test_backpressure();
    test_random_traffic(400, 70, 0, 127, 12);
    test_random_traffic(300, 0, 70, 3, 100);
    test_random_traffic(400, 8, 8, 40, 100);
    test_random_traffic(100, 0, 0, 0, 20);
    test_random_traffic(350, 8, 8, 64, 30);

    wait_idle();
    if (answer_q.size() != 0)
      report_mismatch("responses never returned", 64'(answer_q.size()), '0);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
